[rtl/wsdf_pkg.sv]
// ----------------------------------------------------------------------------
// wsdf_pkg - shared types for the WebSocket frame deframer
// Parse phases, opcodes, result kinds and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT_HI  = 3'd2,
    PH_EXT_LO  = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_HALT    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TEXT  = 3'd0,
    KIND_PING  = 3'd1,
    KIND_EPING = 3'd2,
    KIND_CLOSE = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // One classified result on its way to the back end.
  typedef struct packed {
    logic [7:0] data;    // raw payload byte, 0 for events
    logic [7:0] key;     // mask key byte for this payload position
    logic       unmask;  // apply key to data
    kind_t      kind;
    logic       last;
  } entry_t;

endpackage

[rtl/websocket_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit - WebSocket receive frame parser
// A result passes through the queue and then the output register before it reaches out_*.
// Throughput: one byte per cycle while the queue has room; the parser steps once per accepted byte.
// A 2-entry queue and an output register decouple input from output stalls.
// Reset (rst_n low, synchronous): parser to frame start, queue and output empty.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       in_tuser,   // [0] resync
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_byte
  output logic [2:0] out_tuser,  // [2:0] kind
  output logic       out_tlast   // last_of_frame
);

  // Front: header state machine, classifies each byte, at most one
  // result per accepted item.
  logic             item_fire;
  logic             emit;
  wsdf_pkg::entry_t entry;

  // Queue status and head
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  wsdf_pkg::entry_t q_head;

  // Ready depends only on queue space, so a waiting result never blocks
  // the next byte while there is room.
  assign in_tready = !q_full;
  assign item_fire = in_tvalid && in_tready;

  wsdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (item_fire),
    .rx_byte   (in_tdata),
    .resync    (in_tuser),
    .emit      (emit),
    .entry     (entry)
  );

  wsdf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (emit),
    .push_entry (entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  // Back: unmask text bytes into the output register.
  wsdf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/wsdf_front.sv]
// ----------------------------------------------------------------------------
// wsdf_front - header parser and byte classifier
// Walks the frame header, holds length and mask key, tags each payload byte.
// ----------------------------------------------------------------------------
module wsdf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_fire,
  input  logic [7:0]          rx_byte,
  input  logic                resync,
  output logic                emit,
  output wsdf_pkg::entry_t    entry
);

  wsdf_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        mask_r, mask_nxt;
  logic [31:0] key_r, key_nxt;
  logic [15:0] left_r, left_nxt;
  logic [1:0]  idx_r, idx_nxt;

  logic        hdr_done;
  logic [15:0] left_dec;
  logic        pay_last;
  logic [7:0]  key_byte;

  assign left_dec = left_r - 16'd1;
  assign pay_last = (left_dec == '0);

  always_comb begin
    case (idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Next state
  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    mask_nxt   = mask_r;
    key_nxt    = key_r;
    left_nxt   = left_r;
    idx_nxt    = idx_r;
    hdr_done   = 1'b0;

    if (item_fire) begin
      if (resync) begin
        phase_nxt  = wsdf_pkg::PH_HDR0;
        opcode_nxt = '0;
        mask_nxt   = 1'b0;
        key_nxt    = '0;
        left_nxt   = '0;
        idx_nxt    = '0;
      end else begin
        unique case (phase_r)
          wsdf_pkg::PH_HDR0: begin
            opcode_nxt = rx_byte[3:0];
            phase_nxt  = wsdf_pkg::PH_HDR1;
          end
          wsdf_pkg::PH_HDR1: begin
            mask_nxt = rx_byte[7];
            if (rx_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
              phase_nxt = wsdf_pkg::PH_HALT;
            end else if (rx_byte[6:0] == wsdf_pkg::LEN_EXT16) begin
              phase_nxt = wsdf_pkg::PH_EXT_HI;
            end else begin
              left_nxt = {9'd0, rx_byte[6:0]};
              if (rx_byte[7]) begin
                idx_nxt   = '0;
                phase_nxt = wsdf_pkg::PH_KEY;
              end else begin
                hdr_done = 1'b1;
              end
            end
          end
          wsdf_pkg::PH_EXT_HI: begin
            left_nxt  = {rx_byte, 8'd0};
            phase_nxt = wsdf_pkg::PH_EXT_LO;
          end
          wsdf_pkg::PH_EXT_LO: begin
            left_nxt = {left_r[15:8], rx_byte};
            if (mask_r) begin
              idx_nxt   = '0;
              phase_nxt = wsdf_pkg::PH_KEY;
            end else begin
              hdr_done = 1'b1;
            end
          end
          wsdf_pkg::PH_KEY: begin
            key_nxt = {key_r[23:0], rx_byte};
            if (idx_r == 2'd3) hdr_done = 1'b1;
            else               idx_nxt  = idx_r + 2'd1;
          end
          wsdf_pkg::PH_PAYLOAD: begin
            left_nxt = left_dec;
            idx_nxt  = idx_r + 2'd1;
            if (pay_last) begin
              phase_nxt = (opcode_r == wsdf_pkg::OP_CLOSE) ? wsdf_pkg::PH_HALT
                                                           : wsdf_pkg::PH_HDR0;
            end
          end
          wsdf_pkg::PH_HALT: begin
          end
          default: phase_nxt = wsdf_pkg::PH_HALT;
        endcase

        // Header complete: payload phase, or back to start / halt when empty.
        if (hdr_done) begin
          idx_nxt = '0;
          if (left_nxt != '0) begin
            phase_nxt = wsdf_pkg::PH_PAYLOAD;
          end else if (opcode_r == wsdf_pkg::OP_CLOSE) begin
            phase_nxt = wsdf_pkg::PH_HALT;
          end else begin
            phase_nxt = wsdf_pkg::PH_HDR0;
          end
        end
      end
    end
  end

  // Outputs: result tagging
  always_comb begin
    emit  = 1'b0;
    entry = '{data: 8'd0, key: 8'd0, unmask: 1'b0,
              kind: wsdf_pkg::KIND_TEXT, last: 1'b0};

    if (item_fire && !resync) begin
      unique case (phase_r)
        wsdf_pkg::PH_HDR1: begin
          if (rx_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
            emit       = 1'b1;
            entry.kind = wsdf_pkg::KIND_ERROR;
            entry.last = 1'b1;
          end
        end
        wsdf_pkg::PH_PAYLOAD: begin
          entry.last = pay_last;
          if (opcode_r == wsdf_pkg::OP_TEXT) begin
            emit         = 1'b1;
            entry.data   = rx_byte;
            entry.key    = key_byte;
            entry.unmask = mask_r;
            entry.kind   = wsdf_pkg::KIND_TEXT;
          end else if (opcode_r == wsdf_pkg::OP_PING) begin
            emit       = 1'b1;
            entry.data = rx_byte;
            entry.kind = wsdf_pkg::KIND_PING;
          end else if (opcode_r == wsdf_pkg::OP_CLOSE && pay_last) begin
            emit       = 1'b1;
            entry.kind = wsdf_pkg::KIND_CLOSE;
          end
        end
        default: begin
        end
      endcase

      // Empty frame: report close or empty ping once the header is in.
      if (hdr_done && left_nxt == '0) begin
        if (opcode_r == wsdf_pkg::OP_CLOSE) begin
          emit       = 1'b1;
          entry.kind = wsdf_pkg::KIND_CLOSE;
          entry.last = 1'b1;
        end else if (opcode_r == wsdf_pkg::OP_PING) begin
          emit       = 1'b1;
          entry.kind = wsdf_pkg::KIND_EPING;
          entry.last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsdf_pkg::PH_HDR0;
      opcode_r <= '0;
      mask_r   <= 1'b0;
      key_r    <= '0;
      left_r   <= '0;
      idx_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      mask_r   <= mask_nxt;
      key_r    <= key_nxt;
      left_r   <= left_nxt;
      idx_r    <= idx_nxt;
    end
  end

endmodule

[rtl/wsdf_queue.sv]
// ----------------------------------------------------------------------------
// wsdf_queue - two-entry queue between parser and output stage
// Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module wsdf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wsdf_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output wsdf_pkg::entry_t head
);

  wsdf_pkg::entry_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[rtl/wsdf_back.sv]
// ----------------------------------------------------------------------------
// wsdf_back - unmask and output register
// Applies the mask key to text bytes and holds the result for the sink.
// ----------------------------------------------------------------------------
module wsdf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  wsdf_pkg::entry_t q_head,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic [2:0]       out_tuser,
  output logic             out_tlast
);

  logic             valid_r, valid_nxt;
  logic [7:0]       data_r;
  wsdf_pkg::kind_t  kind_r;
  logic             last_r;

  assign q_pop     = q_valid && (!valid_r || out_tready);
  assign valid_nxt = q_pop || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= q_head.unmask ? (q_head.data ^ q_head.key) : q_head.data;
      kind_r <= q_head.kind;
      last_r <= q_head.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

[test/websocket_frame_deframer_unit_test.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit_test - self-checking bench for the deframer
// Streams bytes into the parser: a short scripted sequence first, then random
// frames (text, ping, close, skipped opcodes, 16-bit lengths, length errors,
// cut-off frames and line noise). Every accepted byte runs through a local
// parser model; each result item is compared in order with its prediction.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit_test;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  websocket_frame_deframer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One predicted result; hit = 0 means the byte produces nothing.
  typedef struct packed {
    logic            hit;
    logic [7:0]      data;
    wsdf_pkg::kind_t kind;
    logic            last;
  } deframe_out_t;

  // Scripted row: byte, resync flag, and an optional hand-written result.
  typedef struct packed {
    logic [7:0]   rx;
    logic         rs;
    logic         typed;
    deframe_out_t want;
  } row_t;

  localparam int unsigned ITEM_TARGET = 1900;
  localparam int unsigned LONG_HOLD   = 200;

  // Parser model state
  wsdf_pkg::phase_t ps_phase;
  logic [3:0]  ps_opcode;
  logic        ps_masked;
  logic [31:0] ps_key;
  logic [15:0] ps_left;
  logic [1:0]  ps_key_idx;

  deframe_out_t deframed_q[$];
  logic [7:0]   frame_bytes[$];

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  bit          steady       = 1'b0;  // no random idle gaps on either side while set

  // Scripted opening: resync, masked text, ping, empty ping, 16-bit length,
  // 64-bit length error with a halted byte, empty close.
  row_t script [25] = '{
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'h81, 1'b0, 1'b0, '0},
    '{8'h81, 1'b0, 1'b0, '0},
    '{8'hA5, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h3C, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b0, '0},
    '{8'h89, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, '{1'b1, 8'hFF, wsdf_pkg::KIND_PING, 1'b1}},
    '{8'h89, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, '{1'b1, 8'h00, wsdf_pkg::KIND_EPING, 1'b1}},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h7E, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, '{1'b1, 8'h00, wsdf_pkg::KIND_TEXT, 1'b1}},
    '{8'h81, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, '{1'b1, 8'h00, wsdf_pkg::KIND_ERROR, 1'b1}},
    '{8'h89, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h88, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, '{1'b1, 8'h00, wsdf_pkg::KIND_CLOSE, 1'b1}},
    '{8'h00, 1'b1, 1'b0, '0}
  };

  function automatic void clear_parser();
    ps_phase   = wsdf_pkg::PH_HDR0;
    ps_opcode  = 4'h0;
    ps_masked  = 1'b0;
    ps_key     = 32'h0;
    ps_left    = 16'h0;
    ps_key_idx = 2'd0;
  endfunction

  function automatic deframe_out_t event_out(wsdf_pkg::kind_t k);
    deframe_out_t r;
    r = '0;
    r.hit  = 1'b1;
    r.kind = k;
    r.last = 1'b1;
    return r;
  endfunction

  // Header (and key) complete: payload, or an event for empty ping/close.
  function automatic deframe_out_t finish_header();
    ps_key_idx = 2'd0;
    if (ps_left != 16'h0) begin
      ps_phase = wsdf_pkg::PH_PAYLOAD;
      return '0;
    end
    if (ps_opcode == wsdf_pkg::OP_CLOSE) begin
      ps_phase = wsdf_pkg::PH_HALT;
      return event_out(wsdf_pkg::KIND_CLOSE);
    end
    ps_phase = wsdf_pkg::PH_HDR0;
    if (ps_opcode == wsdf_pkg::OP_PING) return event_out(wsdf_pkg::KIND_EPING);
    return '0;
  endfunction

  function automatic deframe_out_t finish_length();
    if (ps_masked) begin
      ps_key_idx = 2'd0;
      ps_phase   = wsdf_pkg::PH_KEY;
      return '0;
    end
    return finish_header();
  endfunction

  // Advance the parser model by one byte and return what it emits.
  function automatic deframe_out_t deframe_byte(logic [7:0] rx, logic rs);
    deframe_out_t r;
    logic [6:0]   len7;
    logic [7:0]   kb;
    logic         fin;
    r = '0;
    if (rs) begin
      clear_parser();
      return r;
    end
    case (ps_phase)
      wsdf_pkg::PH_HDR0: begin
        ps_opcode = rx[3:0];  // FIN/RSV ignored
        ps_phase  = wsdf_pkg::PH_HDR1;
      end
      wsdf_pkg::PH_HDR1: begin
        ps_masked = rx[7];
        len7      = rx[6:0];
        if (len7 == wsdf_pkg::LEN_EXT64) begin
          ps_phase = wsdf_pkg::PH_HALT;
          r = event_out(wsdf_pkg::KIND_ERROR);
        end else if (len7 == wsdf_pkg::LEN_EXT16) begin
          ps_phase = wsdf_pkg::PH_EXT_HI;
        end else begin
          ps_left = {9'd0, len7};
          r = finish_length();
        end
      end
      wsdf_pkg::PH_EXT_HI: begin
        ps_left  = {rx, 8'h00};
        ps_phase = wsdf_pkg::PH_EXT_LO;
      end
      wsdf_pkg::PH_EXT_LO: begin
        ps_left[7:0] = rx;
        r = finish_length();
      end
      wsdf_pkg::PH_KEY: begin
        ps_key = {ps_key[23:0], rx};  // first key byte ends up on top
        if (ps_key_idx == 2'd3) r = finish_header();
        else ps_key_idx = ps_key_idx + 2'd1;
      end
      wsdf_pkg::PH_PAYLOAD: begin
        ps_left    = ps_left - 16'd1;
        fin        = (ps_left == 16'h0);
        kb         = ps_key[8 * (3 - ps_key_idx) +: 8];
        ps_key_idx = ps_key_idx + 2'd1;
        if (fin) begin
          ps_phase = (ps_opcode == wsdf_pkg::OP_CLOSE) ? wsdf_pkg::PH_HALT
                                                       : wsdf_pkg::PH_HDR0;
        end
        if (ps_opcode == wsdf_pkg::OP_TEXT) begin
          r.hit  = 1'b1;
          r.data = ps_masked ? (rx ^ kb) : rx;
          r.kind = wsdf_pkg::KIND_TEXT;
          r.last = fin;
        end else if (ps_opcode == wsdf_pkg::OP_PING) begin
          // ping bytes pass through untouched, mask or not
          r.hit  = 1'b1;
          r.data = rx;
          r.kind = wsdf_pkg::KIND_PING;
          r.last = fin;
        end else if (ps_opcode == wsdf_pkg::OP_CLOSE && fin) begin
          r = event_out(wsdf_pkg::KIND_CLOSE);
        end
      end
      wsdf_pkg::PH_HALT: begin
      end
      default: ps_phase = wsdf_pkg::PH_HALT;
    endcase
    return r;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item from a falling edge; on acceptance update the model and
  // queue the expected result (hand-written one if the row carries it).
  task automatic send_item(logic [7:0] rx, logic rs, logic typed, deframe_out_t want);
    int unsigned  gap;
    deframe_out_t pred;
    gap = steady ? 0 : pick_gap();
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    in_tuser  <= rs;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    pred = deframe_byte(rx, rs);
    if (typed) deframed_q.insert(deframed_q.size(), want);
    else if (pred.hit) deframed_q.insert(deframed_q.size(), pred);
    @(negedge clk);
  endtask

  // One random frame; a broken one may be cut short and is followed by resync.
  task automatic send_frame(bit broken);
    logic [3:0]  op;
    logic        masked;
    logic [7:0]  hi;
    logic [7:0]  lo;
    int unsigned r;
    int unsigned plen;
    int unsigned cut;
    frame_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 40) op = wsdf_pkg::OP_TEXT;
    else if (r < 65) op = wsdf_pkg::OP_PING;
    else if (r < 75) op = wsdf_pkg::OP_CLOSE;
    else begin
      do op = 4'($urandom_range(0, 15));
      while (op == wsdf_pkg::OP_TEXT || op == wsdf_pkg::OP_CLOSE ||
             op == wsdf_pkg::OP_PING);
    end
    masked = 1'($urandom_range(0, 1));
    frame_bytes.insert(frame_bytes.size(), {4'($urandom_range(0, 15)), op});
    r = $urandom_range(0, 99);
    plen = 0;
    if (r < 5) begin
      frame_bytes.insert(frame_bytes.size(), {masked, wsdf_pkg::LEN_EXT64});
    end else begin
      if (r < 20) begin
        hi = ($urandom_range(0, 19) == 0) ? 8'd1 : 8'd0;
        lo = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 40));
        plen = {16'd0, hi, lo};
        frame_bytes.insert(frame_bytes.size(), {masked, wsdf_pkg::LEN_EXT16});
        frame_bytes.insert(frame_bytes.size(), hi);
        frame_bytes.insert(frame_bytes.size(), lo);
      end else begin
        plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 8);
        frame_bytes.insert(frame_bytes.size(), {masked, 7'(plen)});
      end
      if (masked) begin
        repeat (4) frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 255)));
      end
      repeat (plen) frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 255)));
    end
    cut = broken ? $urandom_range(1, frame_bytes.size()) : frame_bytes.size();
    for (int i = 0; i < cut; i++) send_item(frame_bytes[i], 1'b0, 1'b0, '0);
    if (broken) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
  endtask

  // Receiver: random ready gaps, plus one long hold once traffic is flowing
  // so the internal queue fills and the input side backs up.
  int unsigned ready_gap = 0;
  int unsigned hold_left = 0;
  bit          held_long = 1'b0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else if (!held_long && results_seen >= 300) begin
      held_long  = 1'b1;
      hold_left  = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap  = ready_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      ready_gap  = steady ? 0 : pick_gap();
    end
  end

  // Result checker
  always @(posedge clk) begin
    deframe_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (deframed_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result data %02h kind %0d last %0d",
                   $time, out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        want = deframed_q.pop_front();
        if (out_tdata !== want.data || out_tuser !== want.kind || out_tlast !== want.last)
        begin
          if (mismatches < 10)
            $display("%0t: expected data %02h kind %0d last %0d, got %02h %0d %0d",
                     $time, want.data, want.kind, want.last,
                     out_tdata, out_tuser, out_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned r;
    bit          drained_once;
    drained_once = 1'b0;
    clear_parser();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 25; i++)
      send_item(script[i].rx, script[i].rs, script[i].typed, script[i].want);

    while (items_sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 99) < 15);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        send_frame(1'b0);
      end else if (r < 88) begin
        send_frame(1'b1);
      end else if (r < 95) begin
        // line noise, then resync so the stream does not lose framing
        repeat ($urandom_range(1, 6))
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      end else begin
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      end
      // halted after close or length error: a few dead bytes, then resync
      if (ps_phase == wsdf_pkg::PH_HALT) begin
        repeat ($urandom_range(0, 3))
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      end
      // sender goes quiet once until the output side has caught up
      if (!drained_once && items_sent >= ITEM_TARGET / 2) begin
        drained_once = 1'b1;
        in_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge clk);
        @(negedge clk);
      end
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (deframed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && deframed_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #(8 * 2000000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/wsdf_pkg.sv
rtl/wsdf_front.sv
rtl/wsdf_queue.sv
rtl/wsdf_back.sv
rtl/websocket_frame_deframer_unit.sv
test/websocket_frame_deframer_unit_test.sv
